// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the conflict-free run detector. Simulation only; the
// synthesis branch expands to nothing.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge outside reset.
`define CFRD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cfrd assertion failed");

// Condition that must never be seen outside reset.
`define CFRD_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cfrd forbidden condition seen");

`else

`define CFRD_ASSERT(lbl, clk, rst_n, prop)
`define CFRD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/cfrd_pkg.sv =====
// ---------------------------------------------------------------------------
// cfrd_pkg
// Shared types, constants and helpers of the conflict-free run detector.
// ---------------------------------------------------------------------------
package cfrd_pkg;

  // Number of samples taking part (2..64).
  localparam int unsigned SAMPLES           = 64;
  // Saturation point of the per-chromosome counters.
  localparam int unsigned MAX_CHROM_MARKERS = 1048576;

  localparam int unsigned CNT_W   = $clog2(MAX_CHROM_MARKERS + 1);
  localparam int unsigned IDX_W   = 20;
  localparam int unsigned CHROM_W = 8;
  localparam int unsigned POS_W   = 31;
  localparam int unsigned SNP_W   = 21;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned CFG_W   = 64;

  localparam logic [CNT_W-1:0] MaxChromMarkers = CNT_W'(MAX_CHROM_MARKERS);
  localparam logic [IDX_W-1:0] IdxLimit        = '1;
  localparam logic [MASK_W-1:0] SampleBits =
      (SAMPLES >= 64) ? '1 : ((MASK_W'(1) << SAMPLES) - MASK_W'(1));

  // Item kinds carried in the mode field.
  localparam logic ModeMarker = 1'b0;
  localparam logic ModeFlush  = 1'b1;

  typedef enum logic [1:0] {
    CfgSampleMask  = 2'd0,
    CfgMinGenDist  = 2'd1,
    CfgMinSnpCount = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               mode;
    logic [CHROM_W-1:0] chromosome;
    logic [POS_W-1:0]   gen_pos;
    logic [MASK_W-1:0]  hom_aa;
    logic [MASK_W-1:0]  hom_bb;
  } in_item_t;

  typedef struct packed {
    logic [CHROM_W-1:0] region_chromosome;
    logic [IDX_W-1:0]   first_marker;
    logic [IDX_W-1:0]   last_marker;
  } out_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] sample_mask;
    logic [POS_W-1:0]  min_span;
    logic [SNP_W-1:0]  min_markers;
  } cfg_t;

  // Clamp a counter-derived index to the reported field width.
  function automatic logic [IDX_W-1:0] clamp_idx(logic [CNT_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (32'(v) > 32'(IdxLimit)) r = IdxLimit;
    else                        r = IDX_W'(v);
    return r;
  endfunction

endpackage

// ===== rtl/core/conflict_free_run_detector.sv =====
// ---------------------------------------------------------------------------
// conflict_free_run_detector
// Streams genotype markers, tracks runs of conflict-free markers per
// chromosome and reports each run that meets the length and count limits.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | sink      | in_valid_i/in_stall_o | in_item_i (marker or flush)
//  out     | source    | out_valid_o/out_stall_i | out_item_o (qualified region)
//  cfg     | sink      | cfg_we_i              | cfg_index_i, cfg_data_i
//
//  One item per cycle sustained while the output is not stalled; a result is
//  presented in the cycle after its item leaves stage one.
//  Stage one is the input register, stage two the result register; the run
//  state updates as an item leaves stage one.
//  A held result blocks stage one only; the input register still takes an
//  item if stage one is empty.
//  Reset clears the run state and loads the register defaults.
// ---------------------------------------------------------------------------
module conflict_free_run_detector
  import cfrd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // item input
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  // result output
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  // configuration writes
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // Configuration registers
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgSampleMask:  cfg_d.sample_mask = cfg_data_i[MASK_W-1:0];
        CfgMinGenDist:  cfg_d.min_span    = cfg_data_i[POS_W-1:0];
        CfgMinSnpCount: cfg_d.min_markers = cfg_data_i[SNP_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_mask <= '1;
      cfg_q.min_span    <= POS_W'(40000);
      cfg_q.min_markers <= SNP_W'(100);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Stage one: input register
  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      advance, in_accept;
  // Stage two state, read by the stage one control
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  // Stage one empties whenever the result register is free or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept)    in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_valid_q <= 1'b0;
    else         in_valid_q <= in_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) in_item_q <= in_item_i;
  end

  // Run tracking between the two registers
  logic      step, emit;
  out_item_t result;

  assign step = in_valid_q && advance;

  cfrd_run_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .emit_o   (emit),
    .result_o (result)
  );

  // Stage two: result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = step && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/cfrd_run_tracker.sv =====
// ---------------------------------------------------------------------------
// cfrd_run_tracker
// Run state per chromosome, conflict test and region qualification for one
// item per cycle in which step_i is high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfrd_run_tracker
  import cfrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output logic      emit_o,
  output out_item_t result_o
);

  logic [CHROM_W-1:0] open_chrom_q, open_chrom_d;
  logic               chrom_valid_q, chrom_valid_d;
  logic [CNT_W-1:0]   marker_idx_q, marker_idx_d;
  logic [CNT_W-1:0]   run_len_q, run_len_d;
  logic [POS_W-1:0]   run_start_q, run_start_d;
  logic [POS_W-1:0]   last_pos_q, last_pos_d;

  logic [MASK_W-1:0]  mask, aa, bb;
  logic               conflict, chrom_change, new_chrom, do_check;
  logic [POS_W-1:0]   end_pos;
  logic [CNT_W:0]     count;
  logic [POS_W:0]     limit_pos;
  logic               len_ok, cnt_ok;
  logic [CNT_W-1:0]   run_base, idx_base;

  // Masked conflict: an AA sample and a BB sample together; AA wins a tie.
  assign mask     = cfg_i.sample_mask & SampleBits;
  assign aa       = item_i.hom_aa & mask;
  assign bb       = item_i.hom_bb & ~item_i.hom_aa & mask;
  assign conflict = (aa != '0) && (bb != '0);

  assign chrom_change = chrom_valid_q && (item_i.chromosome != open_chrom_q);
  assign new_chrom    = !chrom_valid_q || (item_i.chromosome != open_chrom_q);

  // One qualification check serves all three ways of closing a run.
  always_comb begin
    if (item_i.mode) begin
      do_check = chrom_valid_q;
      end_pos  = last_pos_q;
      count    = {1'b0, run_len_q};
    end else if (chrom_change) begin
      do_check = 1'b1;
      end_pos  = last_pos_q;
      count    = {1'b0, run_len_q};
    end else begin
      do_check = !new_chrom && conflict;
      end_pos  = item_i.gen_pos;
      count    = {1'b0, run_len_q} + (CNT_W+1)'(1);
    end
  end

  assign limit_pos = {1'b0, run_start_q} + {1'b0, cfg_i.min_span};
  assign len_ok    = {1'b0, end_pos} >= limit_pos;
  assign cnt_ok    = 32'(count) >= 32'(cfg_i.min_markers);
  assign emit_o    = do_check && (run_len_q != '0) && len_ok && cnt_ok;

  assign result_o.region_chromosome = open_chrom_q;
  assign result_o.first_marker      = clamp_idx(marker_idx_q - run_len_q);
  assign result_o.last_marker       = clamp_idx(marker_idx_q - CNT_W'(1));

  assign run_base = new_chrom ? '0 : run_len_q;
  assign idx_base = new_chrom ? '0 : marker_idx_q;

  always_comb begin
    open_chrom_d  = open_chrom_q;
    chrom_valid_d = chrom_valid_q;
    marker_idx_d  = marker_idx_q;
    run_len_d     = run_len_q;
    run_start_d   = run_start_q;
    last_pos_d    = last_pos_q;
    if (step_i) begin
      if (item_i.mode) begin
        chrom_valid_d = 1'b0;
        marker_idx_d  = '0;
        run_len_d     = '0;
      end else begin
        chrom_valid_d = 1'b1;
        open_chrom_d  = item_i.chromosome;
        if (conflict) begin
          run_len_d = '0;
        end else begin
          if (run_base == '0) run_start_d = item_i.gen_pos;
          run_len_d  = (run_base < MaxChromMarkers) ? run_base + CNT_W'(1) : run_base;
          last_pos_d = item_i.gen_pos;
        end
        marker_idx_d = (idx_base < MaxChromMarkers) ? idx_base + CNT_W'(1) : idx_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_chrom_q  <= '0;
      chrom_valid_q <= 1'b0;
      marker_idx_q  <= '0;
      run_len_q     <= '0;
      run_start_q   <= '0;
      last_pos_q    <= '0;
    end else begin
      open_chrom_q  <= open_chrom_d;
      chrom_valid_q <= chrom_valid_d;
      marker_idx_q  <= marker_idx_d;
      run_len_q     <= run_len_d;
      run_start_q   <= run_start_d;
      last_pos_q    <= last_pos_d;
    end
  end

  // The run never holds more markers than the chromosome has seen.
  `CFRD_ASSERT(a_run_within_idx, clk_i, rst_ni, run_len_q <= marker_idx_q)
  // No chromosome open means no run and no index.
  `CFRD_ASSERT(a_closed_empty, clk_i, rst_ni, chrom_valid_q || (run_len_q == '0 && marker_idx_q == '0))
  // Counters stop at the saturation point.
  `CFRD_NEVER(a_idx_sat, clk_i, rst_ni, marker_idx_q > MaxChromMarkers)
  // A flush leaves the chromosome closed and the run empty.
  `CFRD_ASSERT(a_flush_closes, clk_i, rst_ni, step_i && item_i.mode |=> !chrom_valid_q && run_len_q == '0)

endmodule

// ===== dv/cfrd_region_checker.sv =====
// ----------------------------------------------------------------------------
// cfrd_region_checker
// Watches the marker, region and register ports of the run detector, keeps
// its own copy of the run state, predicts every reported region and compares
// it with what leaves the block.
// ----------------------------------------------------------------------------
module cfrd_region_checker
  import cfrd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_item_t         in_item_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_item_t        out_item_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int unsigned      error_count_o,
  output int unsigned      regions_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copy
  logic [MASK_W-1:0]  sample_mask;
  logic [POS_W-1:0]   min_span;
  logic [SNP_W-1:0]   min_markers;
  // run state copy
  logic [CHROM_W-1:0] open_chrom;
  logic               chrom_open;
  logic [CNT_W-1:0]   marker_idx;
  logic [CNT_W-1:0]   run_len;
  logic [POS_W-1:0]   run_start;
  logic [POS_W-1:0]   run_last;

  out_item_t   expected_regions[$];
  int unsigned errors = 0;

  assign error_count_o = errors;

  task automatic report_mismatch(input string what);
    $display("%0t ns  region check: %s", $time, what);
    errors++;
  endtask

  function automatic logic [IDX_W-1:0] to_index(logic [CNT_W-1:0] n);
    return (n > CNT_W'(IdxLimit)) ? IdxLimit : n[IDX_W-1:0];
  endfunction

  // Queue the open run if it is non-empty and long enough on both counts.
  task automatic close_run(input logic [POS_W-1:0] end_pos, input logic [CNT_W:0] count,
                           output bit hit);
    out_item_t region;
    hit = 1'b0;
    if (run_len != '0 &&
        {1'b0, end_pos} >= {1'b0, run_start} + {1'b0, min_span} &&
        count >= (CNT_W+1)'(min_markers)) begin
      region.region_chromosome = open_chrom;
      region.first_marker      = to_index(marker_idx - run_len);
      region.last_marker       = to_index(marker_idx - 1'b1);
      expected_regions.insert(expected_regions.size(), region);
      hit = 1'b1;
    end
  endtask

  task automatic predict_region(input in_item_t it);
    logic [MASK_W-1:0] taking_part;
    logic [MASK_W-1:0] aa;
    logic [MASK_W-1:0] bb;
    bit                hit;
    hit         = 1'b0;
    taking_part = sample_mask & SampleBits;
    aa          = it.hom_aa & taking_part;
    // a sample flagged both ways counts as AA
    bb          = it.hom_bb & ~it.hom_aa & taking_part;
    if (it.mode == ModeFlush) begin
      if (chrom_open) close_run(run_last, {1'b0, run_len}, hit);
      chrom_open = 1'b0;
      marker_idx = '0;
      run_len    = '0;
    end else begin
      if (chrom_open && it.chromosome != open_chrom) close_run(run_last, {1'b0, run_len}, hit);
      if (!chrom_open || it.chromosome != open_chrom) begin
        chrom_open = 1'b1;
        open_chrom = it.chromosome;
        marker_idx = '0;
        run_len    = '0;
      end
      if (aa != '0 && bb != '0) begin
        // conflict marker counts towards the run and lends its position
        if (!hit) close_run(it.gen_pos, {1'b0, run_len} + 1'b1, hit);
        run_len = '0;
      end else begin
        if (run_len == '0) run_start = it.gen_pos;
        if (run_len < MaxChromMarkers) run_len++;
        run_last = it.gen_pos;
      end
      if (marker_idx < MaxChromMarkers) marker_idx++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      sample_mask   = '1;
      min_span      = POS_W'(40000);
      min_markers   = SNP_W'(100);
      open_chrom    = '0;
      chrom_open    = 1'b0;
      marker_idx    = '0;
      run_len       = '0;
      run_start     = '0;
      run_last      = '0;
      expected_regions.delete();
      regions_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgSampleMask:  sample_mask = cfg_data_i[MASK_W-1:0];
          CfgMinGenDist:  min_span    = cfg_data_i[POS_W-1:0];
          CfgMinSnpCount: min_markers = cfg_data_i[SNP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_regions.size() == 0) begin
          report_mismatch($sformatf("unexpected region chr %0d %0d..%0d",
                                    out_item_i.region_chromosome, out_item_i.first_marker,
                                    out_item_i.last_marker));
        end else begin
          want = expected_regions.pop_front();
          if (out_item_i.region_chromosome != want.region_chromosome)
            report_mismatch($sformatf("region_chromosome got %0d want %0d",
                                      out_item_i.region_chromosome, want.region_chromosome));
          if (out_item_i.first_marker != want.first_marker)
            report_mismatch($sformatf("first_marker got %0d want %0d",
                                      out_item_i.first_marker, want.first_marker));
          if (out_item_i.last_marker != want.last_marker)
            report_mismatch($sformatf("last_marker got %0d want %0d",
                                      out_item_i.last_marker, want.last_marker));
        end
      end
      if (in_valid_i && !in_stall_i) predict_region(in_item_i);
      regions_due_o <= expected_regions.size();
    end
  end

endmodule

// ===== dv/tb_conflict_free_run_detector.sv =====
// ----------------------------------------------------------------------------
// tb_conflict_free_run_detector
// Drives marker and flush items into the run detector under bursty input and
// patterned output stalls, across several register settings, and leaves all
// region checking to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_conflict_free_run_detector
  import cfrd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit  = 4000;  // cycles with no item moving either way
  localparam int unsigned LongMarkers = 120;
  localparam int unsigned PhaseItems  = 165;
  localparam int unsigned PhaseCount  = 7;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  int unsigned error_count;
  int unsigned regions_due;

  // sender burst state; steady turns the gaps off for the long chromosome
  int unsigned       burst_left = 0;
  bit                steady     = 1'b0;
  logic [MASK_W-1:0] cur_mask   = '1;

  conflict_free_run_detector DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  cfrd_region_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_item_i    (out_item),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .error_count_o (error_count),
    .regions_due_o (regions_due)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver: picks a stall style for a stretch of cycles, then another.
  // Free-flowing, light, heavy, and a rotating 8-bit pattern.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  logic [7:0]  stall_pat  = 8'h0F;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 256);
      stall_pat  = 8'($urandom) & 8'hFE;   // keep one open slot per turn
    end else begin
      stall_left--;
    end
    stall_pat = {stall_pat[6:0], stall_pat[7]};
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_pat[0];
    endcase
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run when nothing is accepted for too long.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("conflict_free_run_detector test failed");
        $finish;
      end
    end
  end

  function automatic in_item_t make_item(input logic mode, input logic [CHROM_W-1:0] chrom,
                                         input logic [POS_W-1:0] pos,
                                         input logic [MASK_W-1:0] aa,
                                         input logic [MASK_W-1:0] bb);
    in_item_t it;
    it.mode       = mode;
    it.chromosome = chrom;
    it.gen_pos    = pos;
    it.hom_aa     = aa;
    it.hom_bb     = bb;
    return it;
  endfunction

  // Present one item and hold it until taken. Between bursts valid drops for
  // a random gap; inside a burst the next item follows on the same edge.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!steady && burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 6);
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Stop sending, wait for every predicted region, then give the pipe time
  // to finish items that report nothing.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (regions_due != 0);
    repeat (8) @(posedge clk);
  endtask

  // All three registers on consecutive edges; write enable stays high.
  task automatic load_registers(input logic [MASK_W-1:0] mask,
                                input logic [POS_W-1:0] span,
                                input logic [SNP_W-1:0] cnt);
    cfg_we    <= 1'b1;
    cfg_index <= CfgSampleMask;
    cfg_data  <= CFG_W'(mask);
    @(posedge clk);
    cfg_index <= CfgMinGenDist;
    cfg_data  <= CFG_W'(span);
    @(posedge clk);
    cfg_index <= CfgMinSnpCount;
    cfg_data  <= CFG_W'(cnt);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mask  = mask;
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: mostly rising positions on one chromosome with mostly
  // clean markers, so runs build up and close; flushes, chromosome hops,
  // position jumps and random genotypes are mixed in as noise.
  // --------------------------------------------------------------------------
  task automatic random_phase(input int unsigned n);
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   pos;
    logic [POS_W:0]     sum;
    logic [MASK_W-1:0]  aa;
    logic [MASK_W-1:0]  bb;
    in_item_t           it;
    int unsigned        r;
    chrom = CHROM_W'($urandom_range(0, 255));
    pos   = POS_W'($urandom_range(0, 1000));
    repeat (n) begin
      aa = {$urandom, $urandom};
      bb = {$urandom, $urandom};
      r  = $urandom_range(0, 99);
      if (r < 3) begin
        it = make_item(ModeFlush, CHROM_W'($urandom), POS_W'($urandom), aa, bb);
      end else begin
        if (r < 8) begin
          chrom = CHROM_W'($urandom_range(0, 255));
          pos   = ($urandom_range(0, 7) == 0) ? POS_W'(32'h7FFF_F000 + $urandom_range(0, 4095))
                                              : POS_W'($urandom_range(0, 2000));
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
          pos = POS_W'($urandom);
        end else if (r < 3) begin
          pos = '1;
        end else if (r < 4) begin
          pos = '0;
        end else begin
          sum = {1'b0, pos} + (POS_W+1)'($urandom_range(0, 400));
          pos = sum[POS_W] ? '1 : sum[POS_W-1:0];
        end
        // genotype shape: a tenth conflict-prone, the rest clean in some way
        case ($urandom_range(0, 19))
          0: ;                                    // raw random bits
          1: begin
            aa = MASK_W'(1) << $urandom_range(0, 63);
            bb = MASK_W'(1) << $urandom_range(0, 63);
          end
          2, 3, 4:  bb = bb & aa;                 // BB only where AA also set
          5, 6, 7:  bb = '0;
          8, 9, 10: aa = '0;
          11, 12:   bb = bb & ~cur_mask;          // BB only on excluded samples
          13, 14:   aa = aa & ~cur_mask;
          default: begin
            aa = aa & {$urandom, $urandom};
            bb = bb & (aa | ~cur_mask);
          end
        endcase
        it = make_item(ModeMarker, chrom, pos, aa, bb);
      end
      send_item(it);
    end
  endtask

  initial begin
    logic [MASK_W-1:0] mask;
    logic [POS_W-1:0]  span;
    logic [SNP_W-1:0]  cnt;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ------------------------------------------------------------------------
    // Long chromosome under the reset register values: a conflict closes a
    // run that clears both limits. A short tail run is then closed by a
    // chromosome change, and the next one-marker run by a flush.
    // ------------------------------------------------------------------------
    steady = 1'b1;
    for (int unsigned i = 0; i < LongMarkers; i++)
      send_item(make_item(ModeMarker, 8'd7, POS_W'(500 * i), '0, {$urandom, $urandom}));
    send_item(make_item(ModeMarker, 8'd7, POS_W'(500 * LongMarkers), 64'h1, 64'h2));
    for (int unsigned i = 0; i < 50; i++)
      send_item(make_item(ModeMarker, 8'd7, POS_W'(500 * LongMarkers + 100 * i), '1, '0));
    send_item(make_item(ModeMarker, 8'd8, '0, '0, '0));
    send_item(make_item(ModeFlush, '0, '0, '0, '0));
    steady = 1'b0;
    settle();

    // ------------------------------------------------------------------------
    // Directed cases with low thresholds.
    // ------------------------------------------------------------------------
    load_registers('1, POS_W'(10), SNP_W'(2));
    send_item(make_item(ModeMarker, 8'd0, '0, '0, '0));
    send_item(make_item(ModeMarker, 8'd0, POS_W'(100), '1, '1));      // both flags: AA
    send_item(make_item(ModeMarker, 8'd0, POS_W'(200), 64'h1, 64'h2)); // conflict closes run
    send_item(make_item(ModeMarker, 8'd0, POS_W'(210), 64'h8000_0000_0000_0000, 64'h1));
    send_item(make_item(ModeMarker, 8'd0, POS_W'(300), '0, '1));
    send_item(make_item(ModeMarker, 8'd0, POS_W'(250), '0, '0));      // position goes back
    send_item(make_item(ModeMarker, 8'd255, '1, '1, '0));             // chromosome change
    send_item(make_item(ModeMarker, 8'd255, '1, '0, '0));
    send_item(make_item(ModeFlush, '1, '1, '1, '1));                  // too short
    send_item(make_item(ModeFlush, '0, '0, '0, '0));                  // nothing open
    send_item(make_item(ModeMarker, 8'd255, '0, '0, '0));             // same number, index 0
    send_item(make_item(ModeMarker, 8'd255, POS_W'(50), '0, '0));
    send_item(make_item(ModeFlush, '0, '0, '0, '0));
    send_item(make_item(ModeMarker, 8'd1, '0, '0, '0));
    send_item(make_item(ModeMarker, 8'd1, '1, '0, '0));
    send_item(make_item(ModeMarker, 8'd1, '1, 64'hFFFF_0000_0000_0000, 64'h0000_FFFF_FFFF_FFFF));
    send_item(make_item(ModeMarker, 8'd2, POS_W'(5), '0, '0));
    send_item(make_item(ModeMarker, 8'd2, POS_W'(40), '0, '0));
    send_item(make_item(ModeMarker, 8'd3, '0, '0, '0));               // reports chromosome 2
    send_item(make_item(ModeMarker, 8'd3, POS_W'(20), 64'h4, 64'h8)); // one-marker run plus conflict
    send_item(make_item(ModeMarker, 8'd3, POS_W'(30), 64'h4, 64'h8)); // empty run
    send_item(make_item(ModeFlush, '0, '0, '0, '0));
    settle();

    // ------------------------------------------------------------------------
    // Random phases, each under its own register setting.
    // ------------------------------------------------------------------------
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin
          mask = '1;
          span = POS_W'($urandom_range(0, 2000));
          cnt  = SNP_W'($urandom_range(1, 6));
        end
        1: begin  // lowest limits
          mask = {$urandom, $urandom};
          span = '0;
          cnt  = SNP_W'(1);
        end
        2: begin  // one or two samples taking part
          mask = (MASK_W'(1) << $urandom_range(0, 63)) | (MASK_W'(1) << $urandom_range(0, 63));
          span = POS_W'($urandom_range(0, 500));
          cnt  = SNP_W'($urandom_range(1, 4));
        end
        3: begin  // no samples: nothing conflicts
          mask = '0;
          span = POS_W'($urandom_range(0, 3000));
          cnt  = SNP_W'($urandom_range(1, 10));
        end
        4: begin  // longest genetic length
          mask = '1;
          span = '1;
          cnt  = SNP_W'(1);
        end
        5: begin  // largest marker count
          mask = {$urandom, $urandom};
          span = POS_W'($urandom);
          cnt  = SNP_W'(MAX_CHROM_MARKERS);
        end
        default: begin  // single sample
          mask = MASK_W'(1) << $urandom_range(0, 63);
          span = POS_W'($urandom_range(0, 1000));
          cnt  = SNP_W'($urandom_range(1, 8));
        end
      endcase
      load_registers(mask, span, cnt);
      random_phase(PhaseItems);
      settle();
    end

    if (error_count == 0) begin
      $display("conflict_free_run_detector test passed");
    end else begin
      $display("conflict_free_run_detector test failed");
    end
    $finish;
  end

endmodule
